[src/sspt_pkg.sv]
// ---------------------------------------------------------------------------
// sspt_pkg: shared types and constants
// Widths, mode codes and controller interface types for the snap table.
// ---------------------------------------------------------------------------
package sspt_pkg;
	localparam int TABLE_ENTRIES = 64;
	localparam int COUNT_BITS    = 16;
	localparam int POS_BITS      = 31;
	localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
	localparam int OCC_BITS      = $clog2(TABLE_ENTRIES + 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic [2:0] MODE_ADD      = 3'd0;
	localparam logic [2:0] MODE_REMOVE   = 3'd1;
	localparam logic [2:0] MODE_CLOSEST  = 3'd2;
	localparam logic [2:0] MODE_NEXT     = 3'd3;
	localparam logic [2:0] MODE_PREVIOUS = 3'd4;

	typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_OUTPUT} state_t;

	typedef struct packed {
		logic capture;   // latch the incoming word
		logic execute;   // compute result and update the cells
	} ctrl_cmd_t;
endpackage

[src/sspt_datapath.sv]
// ---------------------------------------------------------------------------
// sspt_datapath: sorted cell chain
// Holds the cells, compares all of them against the key at once and
// shifts or selects in the following cycle.
// ---------------------------------------------------------------------------
module sspt_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sspt_pkg::ctrl_cmd_t     cmd,
	input  logic [2:0]              mode,
	input  logic [30:0]             position,
	output logic [31:0]             result_position,
	output logic                    status
);
	import sspt_pkg::*;

	logic [POS_BITS-1:0]   pos_q [TABLE_ENTRIES];
	logic [COUNT_BITS-1:0] cnt_q [TABLE_ENTRIES];
	logic [OCC_BITS-1:0]   occ_q;
	logic [2:0]            mode_q;
	logic [POS_BITS-1:0]   key_q;
	logic [TABLE_ENTRIES-1:0] ge_s1, gt_s1, eq_s1; // registered comparisons

	// Stage one: compare every valid cell.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			key_q  <= position;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				ge_s1[i] <= (i < occ_q) && (pos_q[i] >= position);
				gt_s1[i] <= (i < occ_q) && (pos_q[i] > position);
				eq_s1[i] <= (i < occ_q) && (pos_q[i] == position);
			end
		end
	end

	// Boundaries: the cells form a sorted chain, so the ge and gt flag vectors
	// are thermometers and their boundaries are found by neighbor compare.
	logic [IDX_BITS-1:0] at_ge, at_gt;
	logic any_ge, any_gt, hit;
	logic [IDX_BITS-1:0] at_eq;
	always_comb begin
		at_ge = '0; at_gt = '0; at_eq = '0;
		any_ge = |ge_s1; any_gt = |gt_s1; hit = |eq_s1;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (ge_s1[i] && (i == 0 || !ge_s1[i-1])) at_ge = IDX_BITS'(i);
			if (gt_s1[i] && (i == 0 || !gt_s1[i-1])) at_gt = IDX_BITS'(i);
			if (eq_s1[i]) at_eq = IDX_BITS'(i);
		end
	end

	logic [POS_BITS-1:0] below, above, last;
	logic [IDX_BITS-1:0] last_idx;
	assign last_idx = IDX_BITS'(occ_q - 1'b1);
	assign last  = pos_q[last_idx];
	assign above = pos_q[at_ge];
	assign below = any_ge ? pos_q[at_ge - 1'b1] : last;
	logic has_below;
	assign has_below = any_ge ? (at_ge != '0) : (occ_q != '0);

	logic full;
	assign full = (occ_q == OCC_BITS'(TABLE_ENTRIES));

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			result_position <= {1'b0, key_q};
			status <= 1'b0;
			case (mode_q)
				MODE_CLOSEST: begin
					if (occ_q == '0) result_position <= '1;
					else if (!has_below) result_position <= {1'b0, above};
					else if (!any_ge) result_position <= {1'b0, last};
					else if ((key_q - below) < (above - key_q))
						result_position <= {1'b0, below};
					else result_position <= {1'b0, above};
				end
				MODE_NEXT: if (any_gt) result_position <= {1'b0, pos_q[at_gt]};
				MODE_PREVIOUS: result_position <= has_below ? {1'b0, below} : '0;
				MODE_ADD: if (!hit && full) status <= 1'b1;
				default: ;
			endcase
		end
	end

	// Cell updates: each cell takes from itself, a neighbor or the key.
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (mode_q == MODE_ADD) begin
					if (hit) begin
						if (eq_s1[i] && cnt_q[i] != COUNT_MAX) cnt_q[i] <= cnt_q[i] + 1'b1;
					end else if (!full) begin
						if (ge_s1[i] || i == occ_q) begin
							if (i > 0 && ge_s1[i > 0 ? i-1 : 0] && i > 0) begin
								pos_q[i] <= pos_q[i > 0 ? i-1 : 0];
								cnt_q[i] <= cnt_q[i > 0 ? i-1 : 0];
							end else if (i > 0 && i == occ_q && any_ge) begin
								pos_q[i] <= pos_q[i-1];
								cnt_q[i] <= cnt_q[i-1];
							end else begin
								pos_q[i] <= key_q;
								cnt_q[i] <= COUNT_BITS'(1);
							end
						end
					end
				end else if (mode_q == MODE_REMOVE && hit) begin
					if (cnt_q[at_eq] != COUNT_BITS'(1)) begin
						if (eq_s1[i]) cnt_q[i] <= cnt_q[i] - 1'b1;
					end else if (i < TABLE_ENTRIES - 1 && ge_s1[i]) begin
						pos_q[i] <= pos_q[i < TABLE_ENTRIES-1 ? i+1 : i];
						cnt_q[i] <= cnt_q[i < TABLE_ENTRIES-1 ? i+1 : i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.execute) begin
			if (mode_q == MODE_ADD && !hit && !full) occ_q <= occ_q + 1'b1;
			else if (mode_q == MODE_REMOVE && hit && cnt_q[at_eq] == COUNT_BITS'(1))
				occ_q <= occ_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (arst_n) begin
			assert (occ_q <= OCC_BITS'(TABLE_ENTRIES)) else $error("occupancy overflow");
		end
	end
	property p_cnt;
		@(posedge clk) disable iff (!arst_n) cmd.execute |-> $onehot0(eq_s1);
	endproperty
	a_cnt: assert property (p_cnt) else $error("duplicate stored point");
	property p_occ_step;
		@(posedge clk) disable iff (!arst_n) !$past(cmd.execute) |-> $stable(occ_q);
	endproperty
	a_occ_step: assert property (p_occ_step) else $error("occupancy moved while idle");
	property p_full_status;
		@(posedge clk) disable iff (!arst_n) status && $past(cmd.execute) |-> $past(full);
	endproperty
	a_full_status: assert property (p_full_status) else $error("full flag without full table");
endmodule

[src/sspt_ctrl.sv]
// ---------------------------------------------------------------------------
// sspt_ctrl: sequencing controller
// Steps each word through compare, execute and output hand-off.
// ---------------------------------------------------------------------------
module sspt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output sspt_pkg::ctrl_cmd_t cmd
);
	import sspt_pkg::*;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_SEARCH;
			ST_SEARCH: state_d = ST_OUTPUT;
			ST_OUTPUT: if (m_tready) state_d = s_tvalid ? ST_SEARCH : ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.capture = s_tvalid;
			end
			ST_SEARCH: cmd.execute = 1'b1;
			ST_OUTPUT: begin
				m_tvalid = 1'b1;
				s_tready = m_tready;
				cmd.capture = m_tready && s_tvalid;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	property p_exec;
		@(posedge clk) disable iff (!arst_n) cmd.execute |=> m_tvalid;
	endproperty
	a_exec: assert property (p_exec) else $error("result not presented");
	property p_hold;
		@(posedge clk) disable iff (!arst_n) m_tvalid && !m_tready |=> m_tvalid;
	endproperty
	a_hold: assert property (p_hold) else $error("result dropped");
	property p_cap;
		@(posedge clk) disable iff (!arst_n) cmd.capture |=> cmd.execute;
	endproperty
	a_cap: assert property (p_cap) else $error("captured word not executed");
endmodule

[src/sorted_snap_point_table_top.sv]
// ---------------------------------------------------------------------------
// sorted_snap_point_table_top: sorted reference-counted snap table
// Add, remove and nearest-point queries over a sorted cell chain.
// ---------------------------------------------------------------------------
// Channel   Dir  Word contents
// s_axis    in   tdata[2:0] mode, tdata[33:3] position
// m_axis    out  tdata[31:0] result_position, tdata[32] status
//
// Each word first compares the key against all cells in parallel and
// then shifts the cells or selects the answer. A new word is
// taken in the cycle its predecessor's result is taken, so back-pressure
// on the output stalls input. Reset clears the controller state and the
// occupancy count; the cells are never read before they are written.
module sorted_snap_point_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // mode, position, zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // result_position, status, zero fill
);
	import sspt_pkg::*;

	ctrl_cmd_t cmd;
	logic [31:0] result_position;
	logic status;

	sspt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
		.m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
		.cmd(cmd)
	);

	sspt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.mode(s_axis_tdata[2:0]), .position(s_axis_tdata[33:3]),
		.result_position(result_position), .status(status)
	);

	assign m_axis_tdata = {7'd0, status, result_position};
endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for the sorted snap point table
// Drives add, remove and query words with random bursts and output stalls,
// predicts each result from a private copy of the table and checks it.
// ---------------------------------------------------------------------------
import sspt_pkg::*;

// Scoreboard: mirrors the sorted table and queues the predicted results.
class snap_scoreboard;
	logic [POS_BITS-1:0]   pts[TABLE_ENTRIES];
	logic [COUNT_BITS-1:0] cnts[TABLE_ENTRIES];
	int                    used;
	logic [32:0]           pending[$];
	int                    errors;

	function new();
		used = 0;
		errors = 0;
	endfunction

	// First index whose stored point is at or above the key.
	function int lower_bound(longint unsigned key);
		for (int i = 0; i < used; i++) begin
			if (longint'(pts[i]) >= key) return i;
		end
		return used;
	endfunction

	// Note an accepted input word and queue its expected result.
	function void note_input(logic [2:0] mode, logic [POS_BITS-1:0] pos);
		int at;
		logic [31:0] res;
		logic st;
		at = lower_bound(pos);
		res = {1'b0, pos};
		st = 1'b0;
		case (mode)
			MODE_ADD: begin
				if (at < used && pts[at] == pos) begin
					if (cnts[at] != COUNT_MAX) cnts[at]++;
				end else if (used >= TABLE_ENTRIES) begin
					st = 1'b1;
				end else begin
					for (int i = used; i > at; i--) begin
						pts[i] = pts[i-1];
						cnts[i] = cnts[i-1];
					end
					pts[at] = pos;
					cnts[at] = 1;
					used++;
				end
			end
			MODE_REMOVE: begin
				if (at < used && pts[at] == pos) begin
					if (cnts[at] > 1) cnts[at]--;
					else begin
						for (int i = at; i + 1 < used; i++) begin
							pts[i] = pts[i+1];
							cnts[i] = cnts[i+1];
						end
						used--;
					end
				end
			end
			MODE_CLOSEST: begin
				if (used == 0) res = '1;
				else if (at == 0) res = {1'b0, pts[0]};
				else if (at >= used) res = {1'b0, pts[used-1]};
				else if (pos - pts[at-1] < pts[at] - pos) res = {1'b0, pts[at-1]};
				else res = {1'b0, pts[at]};
			end
			MODE_NEXT: begin
				at = lower_bound(longint'(pos) + 1);
				if (at < used) res = {1'b0, pts[at]};
			end
			MODE_PREVIOUS: begin
				res = (at > 0) ? {1'b0, pts[at-1]} : 32'd0;
			end
			default: ;
		endcase
		pending.push_back({st, res});
	endfunction

	// Compare an accepted output word with the oldest expectation.
	task check_result(logic [39:0] word);
		logic [32:0] exp_w;
		if (pending.size() == 0) begin
			report($sformatf("unexpected result %h", word));
			return;
		end
		exp_w = pending.pop_front();
		if (word[31:0] !== exp_w[31:0])
			report($sformatf("result_position %h, expected %h", word[31:0], exp_w[31:0]));
		if (word[32] !== exp_w[32])
			report($sformatf("status %b, expected %b", word[32], exp_w[32]));
		if (word[39:33] !== 7'd0)
			report($sformatf("fill bits %h not zero", word[39:33]));
	endtask

	task report(string msg);
		$display("MISMATCH: %s", msg);
		errors++;
	endtask
endclass

module tb_top;
	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;

	snap_scoreboard board;
	int  cycles;
	bit  hold_long;      // request for a long output stall
	logic [POS_BITS-1:0] recent[$];   // positions added lately, reused for hits

	sorted_snap_point_table_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sends one word and waits for its handshake. The valid stays high
	// on return, so back-to-back words never drop it within a step.
	task automatic send_word(logic [2:0] mode, logic [POS_BITS-1:0] pos);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, pos, mode};
		do @(posedge clk); while (!s_axis_tready);
		board.note_input(mode, pos);
		if (mode == MODE_ADD) begin
			recent.push_back(pos);
			if (recent.size() > 80) void'(recent.pop_front());
		end
	endtask

	task automatic idle_gap(int n);
		s_axis_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Picks a position that lands near recently added points half of the time.
	function automatic logic [POS_BITS-1:0] pick_pos();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5 && recent.size() > 0)
			return POS_BITS'(recent[$urandom_range(0, recent.size() - 1)]
			                 + $urandom_range(0, 2) - 1);
		if (sel < 8) return POS_BITS'($urandom_range(0, 200));
		return POS_BITS'($urandom() & 32'h7fff_ffff);
	endfunction

	// Output side: random stalls, plain stretches, and one long hold-off.
	initial begin
		int mode_sel;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
			if (hold_long) begin
				m_axis_tready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_long = 1'b0;
			end else begin
				mode_sel = (cycles / 500) % 3;
				if (mode_sel == 0) m_axis_tready <= 1'b1;
				else m_axis_tready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	// Cycle counter and run-time limit.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 200000) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int n;
		logic [2:0] m;
		board = new();
		hold_long = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: queries on an empty table, extremes, duplicates, absent removes.
		send_word(MODE_CLOSEST, 31'd0);
		send_word(MODE_NEXT, 31'h7fff_ffff);
		send_word(MODE_PREVIOUS, 31'd5);
		send_word(MODE_REMOVE, 31'd9);
		send_word(MODE_ADD, 31'd0);
		send_word(MODE_ADD, 31'h7fff_ffff);
		send_word(MODE_ADD, 31'd100);
		send_word(MODE_ADD, 31'd100);
		send_word(MODE_ADD, 31'd200);
		send_word(MODE_CLOSEST, 31'd150);       // tie picks the higher point
		send_word(MODE_CLOSEST, 31'd149);
		send_word(MODE_NEXT, 31'h7fff_ffff);     // nothing above
		send_word(MODE_NEXT, 31'd100);
		send_word(MODE_PREVIOUS, 31'd0);        // nothing below
		send_word(MODE_PREVIOUS, 31'h7fff_ffff);
		send_word(MODE_REMOVE, 31'd100);
		send_word(MODE_CLOSEST, 31'd100);
		send_word(MODE_REMOVE, 31'd100);
		send_word(MODE_REMOVE, 31'd100);        // absent by now
		send_word(3'd5, 31'h5555_5555);
		send_word(3'd6, 31'h2aaa_aaaa);
		send_word(3'd7, 31'd7);

		// Fill the table to see a dropped add, then raise one count a few times.
		for (int i = 0; i < TABLE_ENTRIES; i++) send_word(MODE_ADD, POS_BITS'(1000 + 3 * i));
		send_word(MODE_ADD, 31'd5);
		send_word(MODE_CLOSEST, 31'd1001);
		for (int i = 0; i < 8; i++) send_word(MODE_ADD, 31'd1000);
		send_word(MODE_REMOVE, 31'd1000);
		send_word(MODE_NEXT, 31'd999);

		// Sender pauses until every result has come, then removes each filled point once.
		s_axis_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		for (int i = 0; i < TABLE_ENTRIES; i++) send_word(MODE_REMOVE, POS_BITS'(1000 + 3 * i));
		send_word(MODE_CLOSEST, 31'd7);

		// Long output hold-off while words keep coming.
		hold_long = 1'b1;
		for (int i = 0; i < 20; i++) send_word(MODE_ADD, POS_BITS'($urandom_range(0, 300)));

		// Random bursts.
		n = 0;
		while (n < 420) begin
			repeat ($urandom_range(1, 12)) begin
				m = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(5, 7))
				                                 : 3'($urandom_range(0, 4));
				if (m == MODE_ADD && $urandom_range(0, 1)) m = MODE_ADD;
				send_word(m, pick_pos());
				n++;
			end
			if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 6));
		end
		s_axis_tvalid <= 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
